// ===== sv/pfac_pkg.sv =====
package pfac_pkg;

    // Palette depth default
    localparam int PALETTE_ENTRIES_DEF = 256;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Item function codes
    localparam logic FUNC_CONVERT       = 1'b0;
    localparam logic FUNC_PALETTE_WRITE = 1'b1;

    // Source pixel formats
    typedef enum logic [1:0] {
        FMT_INDEXED8 = 2'd0,
        FMT_RGB565   = 2'd1,
        FMT_RGB24    = 2'd2,
        FMT_RGB32    = 2'd3
    } fmt_t;

    // RGB565 to {blue, green, red} with high-bit replication
    function automatic logic [23:0] expand_rgb565(input logic [15:0] px);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = px[15:11];
        g6 = px[10:5];
        b5 = px[4:0];
        return {b5, b5[4:2], g6, g6[5:4], r5, r5[4:2]};
    endfunction

endpackage

// ===== sv/pixel_format_to_argb_converter.sv =====
// A convert word passes stage 1 and the output register before argb_pixel is valid.
// One word per cycle unless the output stalls; a palette write gives no result.
// Rate is set by the single-ported palette RAM: one access (read or write) per cycle.
// Reset: pixel_format returns to indexed 8-bit; per-entry valid flops clear at once so
// every palette entry reads as zero; no clearing pass, the block is ready right away.
module pixel_format_to_argb_converter #(
    parameter int PALETTE_ENTRIES = pfac_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,

    // input words
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        func,
    input  logic [31:0] pixel_data,
    input  logic [7:0]  palette_index,
    input  logic [7:0]  red_value,
    input  logic [7:0]  green_value,
    input  logic [7:0]  blue_value,

    // result words
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] argb_pixel
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    pfac_pkg::fmt_t pixel_format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= pfac_pkg::FMT_INDEXED8;
        end
        else if (cfg_we)
        begin
            pixel_format_reg <= pfac_pkg::fmt_t'(cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Handshake / pipeline control
    // Stage 0: accept, palette RAM write or read issue.
    // Stage 1: RAM data back, format conversion.
    // Output register: holds the finished word while downstream stalls.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic result_valid_reg, result_valid_next;
    logic out_ready;
    logic s1_adv;
    logic item_acc;
    logic conv_acc;
    logic wr_acc;

    assign out_ready  = !result_valid_reg || !result_stall;
    assign s1_adv     = s1_valid_reg && out_ready;
    assign item_stall = s1_valid_reg && !out_ready;
    assign item_acc   = item_valid && !item_stall;

    // Writes past the palette depth are dropped; lookups past it give zero.
    logic wr_in_range;
    logic rd_in_range;
    assign wr_in_range = ({1'b0, palette_index} < 9'(PALETTE_ENTRIES));
    assign rd_in_range = ({1'b0, pixel_data[7:0]} < 9'(PALETTE_ENTRIES));

    assign conv_acc = item_acc && (func == pfac_pkg::FUNC_CONVERT);
    assign wr_acc   = item_acc && (func == pfac_pkg::FUNC_PALETTE_WRITE) && wr_in_range;

    always_comb
    begin
        s1_valid_next     = conv_acc || (s1_valid_reg && !out_ready);
        result_valid_next = s1_adv || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Palette RAM: {blue, green, red}; alpha is implied opaque on written
    // entries. Entry valid flops stand in for the zero reset value.
    // Write and read never land on the same edge (one word per edge), and a
    // write is visible to a lookup accepted on the very next edge.
    // ------------------------------------------------------------------
    logic [23:0]                palette_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_valid_reg;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;
    logic [23:0]                rd_data_reg;

    assign wr_addr = palette_index[IDX_W-1:0];
    assign rd_addr = pixel_data[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_acc)
        begin
            palette_mem[wr_addr] <= {blue_value, green_value, red_value};
        end
        if (conv_acc)
        begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (wr_acc)
        begin
            entry_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 payload
    // ------------------------------------------------------------------
    logic [23:0] s1_pixel_reg;
    logic        s1_hit_reg;

    always_ff @(posedge clk)
    begin
        if (conv_acc)
        begin
            s1_pixel_reg <= pixel_data[23:0];
            s1_hit_reg   <= rd_in_range && entry_valid_reg[rd_addr];
        end
    end

    // Conversion
    logic [31:0] conv_pixel;

    always_comb
    begin
        case (pixel_format_reg)
            pfac_pkg::FMT_INDEXED8:
            begin
                conv_pixel = s1_hit_reg ? {pfac_pkg::ALPHA_OPAQUE, rd_data_reg} : 32'd0;
            end
            pfac_pkg::FMT_RGB565:
            begin
                conv_pixel = {pfac_pkg::ALPHA_OPAQUE,
                              pfac_pkg::expand_rgb565(s1_pixel_reg[15:0])};
            end
            default:
            begin
                // 24- and 32-bit: low three bytes, alpha forced opaque
                conv_pixel = {pfac_pkg::ALPHA_OPAQUE, s1_pixel_reg};
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [31:0] argb_pixel_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            argb_pixel_reg <= conv_pixel;
        end
    end

    assign result_valid = result_valid_reg;
    assign argb_pixel   = argb_pixel_reg;

endmodule

// ===== sv/pfac_checker.sv =====
module pfac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_stall,
    input logic        func,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] argb_pixel
);

    logic conv_acc;
    assign conv_acc = item_valid && !item_stall && (func == pfac_pkg::FUNC_CONVERT);

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(argb_pixel))
        else $error("result word changed under stall");

    // input backpressure only from a blocked output
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled with output free");

    // no result word unless a convert word was accepted earlier or a result word was already valid
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(conv_acc) && !$past(conv_acc, 2) && !$past(result_valid) |-> !result_valid)
        else $error("result word without a convert word");

    // back-to-back: free output after a convert word never stalls input
    assert property (@(posedge clk) disable iff (!rst_n)
        conv_acc ##1 !result_valid |-> !item_stall)
        else $error("input stalled with empty output");

endmodule

bind pixel_format_to_argb_converter pfac_checker u_pfac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .argb_pixel   (argb_pixel)
);
